@@ hw/rtl/rsgp_pkg.sv @@
package rsgp_pkg;

	localparam int IN_W  = 40;
	localparam int OUT_W = 24;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD    = 2'd1;
	localparam logic [1:0] ST_NOPRIM = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FINIT,
		OP_FILL,
		OP_INV,
		OP_RSTEP,
		OP_GINIT,
		OP_GSTART,
		OP_GRD,
		OP_GLOG,
		OP_GALOG,
		OP_GWR,
		OP_ERD,
		OP_ELOG,
		OP_ENEXT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       set_err;
		logic [1:0] err_code;
	} cmd_t;

	typedef struct packed {
		logic param_bad;
		logic fill_last;
		logic fill_prim;
		logic inv_found;
		logic inv_fail;
		logic root_ready;
		logic no_roots;
		logic j_zero;
		logic outer_last;
		logic emit_last;
	} stat_t;

endpackage

@@ hw/rtl/rs_generator_poly_builder_core.sv @@
// Channel  Dir  Fields (low bit first)
// s_axis   in   tdata: symbol_bits[3:0] field_poly[12:4] first_root[20:13]
//               root_step[28:21] root_count[36:29], zero fill to 40 bits
// m_axis   out  tdata: coef_position[5:0] coef_log[13:6] inverse_step[21:14],
//               zero fill to 24 bits; tuser: status[1:0]; tlast: last
//
// One request at a time. A build fills the log and antilog tables, searches for
// the inverse step, steps the root offset first_root times, then forms the
// product, each coefficient update passing the read, log, antilog and write
// states set by the registered reads of the coefficient, log and antilog
// memories; each of the r+1 results then passes the read, log and output states.
// Reset returns the controller to idle. A stalled result holds the block.
module rs_generator_poly_builder_core #(
	parameter int MAX_ROOTS       = 63,
	parameter int MAX_SYMBOL_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rsgp_pkg::IN_W-1:0]   s_axis_tdata,  // symbol_bits, field_poly, first_root, root_step, root_count
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [rsgp_pkg::OUT_W-1:0]  m_axis_tdata,  // coef_position, coef_log, inverse_step
	output logic [1:0]                  m_axis_tuser,  // status
	output logic                        m_axis_tlast
);
	import rsgp_pkg::*;

	cmd_t       cmd;
	stat_t      stat;
	logic [5:0] coef_position;
	logic [7:0] coef_log;
	logic [7:0] inverse_step;

	rsgp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rsgp_dp #(
		.MAX_ROOTS       (MAX_ROOTS),
		.MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_data      (s_axis_tdata),
		.status        (m_axis_tuser),
		.coef_position (coef_position),
		.coef_log      (coef_log),
		.inverse_step  (inverse_step),
		.last          (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, inverse_step, coef_log, coef_position};

endmodule

@@ hw/rtl/rsgp_dp.sv @@
module rsgp_dp #(
	parameter int MAX_ROOTS       = 63,
	parameter int MAX_SYMBOL_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsgp_pkg::cmd_t             cmd,
	output rsgp_pkg::stat_t            stat,
	input  logic [rsgp_pkg::IN_W-1:0]  req_data,
	output logic [1:0]                 status,
	output logic [5:0]                 coef_position,
	output logic [7:0]                 coef_log,
	output logic [7:0]                 inverse_step,
	output logic                       last
);
	import rsgp_pkg::*;

	localparam int AW = MAX_SYMBOL_BITS;
	localparam int TD = 1 << AW;
	localparam int CD = MAX_ROOTS + 1;
	localparam int CW = (CD > 1) ? $clog2(CD) : 1;

	function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] n);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[7:0];
	endfunction

	logic [3:0]  m_q;
	logic [8:0]  poly_q;
	logic [7:0]  fcr_q, prim_q, nroots_q;
	logic [1:0]  res_q;
	logic [8:0]  sr_q;
	logic [7:0]  fi_q;
	logic [15:0] acc_q, v_q;
	logic [8:0]  t_q;
	logic [7:0]  k_q, iprim_q, rootm_q, rc_q;
	logic [CW-1:0] i_q, j_q, ei_q;
	logic [7:0]  crd0_q, crd1_q, lrd_q, ard_q;

	logic [7:0] log_mem [TD];
	logic [7:0] alog_mem [TD];
	logic [7:0] coef_mem [CD];

	logic [7:0] nn;
	logic [8:0] size9, sr_sh, sr_fb, sr_nx;
	logic [7:0] e_idx, coef_new;
	logic [CW-1:0] i_inc;

	assign nn    = 8'((9'd1 << m_q) - 9'd1);
	assign size9 = {1'b0, nn} + 9'd1;
	assign sr_sh = {sr_q[7:0], 1'b0};
	assign sr_fb = ((sr_sh & size9) != 9'd0) ? (sr_sh ^ poly_q) : sr_sh;
	assign sr_nx = sr_fb & {1'b0, nn};
	assign e_idx = mod_add(lrd_q, rootm_q, nn);
	assign i_inc = i_q + CW'(1);

	always_comb begin
		if (j_q == '0) begin
			coef_new = ard_q;
		end else if (crd0_q != 8'd0) begin
			coef_new = crd1_q ^ ard_q;
		end else begin
			coef_new = crd1_q;
		end
	end

	always_comb begin
		stat.param_bad  = (m_q == 4'd0) || (m_q > 4'(MAX_SYMBOL_BITS)) || (fcr_q > nn) ||
			(prim_q == 8'd0) || (prim_q > nn) || (nroots_q > nn) ||
			(nroots_q > 8'(MAX_ROOTS));
		stat.fill_last  = (fi_q == nn - 8'd1);
		stat.fill_prim  = (sr_nx == 9'd1);
		stat.inv_found  = (acc_q == v_q);
		stat.inv_fail   = (acc_q > v_q) && (k_q == prim_q - 8'd1);
		stat.root_ready = (rc_q == fcr_q);
		stat.no_roots   = (nroots_q == 8'd0);
		stat.j_zero     = (j_q == '0);
		stat.outer_last = (8'(i_q) + 8'd1 == nroots_q);
		stat.emit_last  = (8'(ei_q) == nroots_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= ST_OK;
			sr_q  <= 9'd1;
		end else begin
			if (cmd.op == OP_LOAD) begin
				res_q <= ST_OK;
			end else if (cmd.set_err) begin
				res_q <= cmd.err_code;
			end
			if (cmd.op == OP_FINIT) begin
				sr_q <= 9'd1;
			end else if (cmd.op == OP_FILL) begin
				sr_q <= sr_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				m_q      <= req_data[3:0];
				poly_q   <= req_data[12:4];
				fcr_q    <= req_data[20:13];
				prim_q   <= req_data[28:21];
				nroots_q <= req_data[36:29];
			end
			OP_FINIT: begin
				fi_q    <= 8'd0;
				acc_q   <= 16'd0;
				v_q     <= 16'd1;
				t_q     <= 9'd0;
				k_q     <= 8'd0;
				rootm_q <= 8'd0;
				rc_q    <= 8'd0;
			end
			OP_FILL: begin
				fi_q <= fi_q + 8'd1;
			end
			OP_INV: begin
				if (acc_q == v_q) begin
					iprim_q <= t_q[7:0];
				end else if (acc_q < v_q) begin
					t_q   <= t_q + 9'd1;
					acc_q <= acc_q + {8'd0, prim_q};
				end else begin
					k_q <= k_q + 8'd1;
					v_q <= v_q + {8'd0, nn};
				end
			end
			OP_RSTEP: begin
				if (rc_q != fcr_q) begin
					rootm_q <= mod_add(rootm_q, prim_q, nn);
					rc_q    <= rc_q + 8'd1;
				end
			end
			OP_GINIT: begin
				i_q  <= '0;
				ei_q <= '0;
			end
			OP_GSTART: begin
				j_q <= i_q;
			end
			OP_GWR: begin
				if (j_q != '0) begin
					j_q <= j_q - CW'(1);
				end else begin
					rootm_q <= mod_add(rootm_q, prim_q, nn);
					i_q     <= i_inc;
				end
			end
			OP_ENEXT: begin
				ei_q <= ei_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	// Field tables: the first write of a fill seeds the zero entries.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINIT) begin
			log_mem[AW'(0)]    <= nn;
			alog_mem[nn[AW-1:0]] <= 8'd0;
		end else if (cmd.op == OP_FILL) begin
			log_mem[sr_q[AW-1:0]] <= fi_q;
			alog_mem[fi_q[AW-1:0]] <= sr_q[7:0];
		end
		if (cmd.op == OP_GLOG || cmd.op == OP_ELOG) begin
			lrd_q <= log_mem[crd0_q[AW-1:0]];
		end
		if (cmd.op == OP_GALOG) begin
			ard_q <= alog_mem[e_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_GINIT) begin
			coef_mem[CW'(0)] <= 8'd1;
		end else if (cmd.op == OP_GSTART) begin
			coef_mem[i_inc] <= 8'd1;
		end else if (cmd.op == OP_GWR) begin
			coef_mem[j_q] <= coef_new;
		end
		if (cmd.op == OP_GRD) begin
			crd0_q <= coef_mem[j_q];
			crd1_q <= coef_mem[j_q - CW'(1)];
		end else if (cmd.op == OP_ERD) begin
			crd0_q <= coef_mem[ei_q];
		end
	end

	always_comb begin
		status = res_q;
		if (res_q == ST_OK) begin
			coef_position = 6'(ei_q);
			coef_log      = lrd_q;
			inverse_step  = iprim_q;
			last          = stat.emit_last;
		end else begin
			coef_position = 6'd0;
			coef_log      = 8'd0;
			inverse_step  = 8'd0;
			last          = 1'b1;
		end
	end

endmodule

@@ hw/rtl/rsgp_ctrl.sv @@
module rsgp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  rsgp_pkg::stat_t stat,
	output rsgp_pkg::cmd_t  cmd
);
	import rsgp_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_CHECK  = 15'b000000000000010,
		S_FILL   = 15'b000000000000100,
		S_INV    = 15'b000000000001000,
		S_RINIT  = 15'b000000000010000,
		S_GINIT  = 15'b000000000100000,
		S_GSTART = 15'b000000001000000,
		S_GRD    = 15'b000000010000000,
		S_GLOG   = 15'b000000100000000,
		S_GALOG  = 15'b000001000000000,
		S_GWR    = 15'b000010000000000,
		S_ERD    = 15'b000100000000000,
		S_ELOG   = 15'b001000000000000,
		S_EOUT   = 15'b010000000000000,
		S_ERR    = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.set_err  = 1'b0;
		cmd.err_code = ST_OK;
		in_ready     = (state_q == S_IDLE);
		out_valid    = (state_q == S_EOUT) || (state_q == S_ERR);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.param_bad) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_BAD;
					state_d      = S_ERR;
				end else begin
					cmd.op  = OP_FINIT;
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.op = OP_FILL;
				if (stat.fill_last) begin
					if (stat.fill_prim) begin
						state_d = S_INV;
					end else begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_NOPRIM;
						state_d      = S_ERR;
					end
				end
			end
			S_INV: begin
				cmd.op = OP_INV;
				if (stat.inv_found) begin
					state_d = S_RINIT;
				end else if (stat.inv_fail) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_BAD;
					state_d      = S_ERR;
				end
			end
			S_RINIT: begin
				cmd.op = OP_RSTEP;
				if (stat.root_ready) begin
					state_d = S_GINIT;
				end
			end
			S_GINIT: begin
				cmd.op  = OP_GINIT;
				state_d = stat.no_roots ? S_ERD : S_GSTART;
			end
			S_GSTART: begin
				cmd.op  = OP_GSTART;
				state_d = S_GRD;
			end
			S_GRD: begin
				cmd.op  = OP_GRD;
				state_d = S_GLOG;
			end
			S_GLOG: begin
				cmd.op  = OP_GLOG;
				state_d = S_GALOG;
			end
			S_GALOG: begin
				cmd.op  = OP_GALOG;
				state_d = S_GWR;
			end
			S_GWR: begin
				cmd.op = OP_GWR;
				if (!stat.j_zero) begin
					state_d = S_GRD;
				end else begin
					state_d = stat.outer_last ? S_ERD : S_GSTART;
				end
			end
			S_ERD: begin
				cmd.op  = OP_ERD;
				state_d = S_ELOG;
			end
			S_ELOG: begin
				cmd.op  = OP_ELOG;
				state_d = S_EOUT;
			end
			S_EOUT: begin
				if (out_ready) begin
					cmd.op  = OP_ENEXT;
					state_d = stat.emit_last ? S_IDLE : S_ERD;
				end
			end
			S_ERR: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
